@@ rtl/res_pkg.sv @@
// Shared types and constants for the repeat event suppressor.
// No dependencies; imported by every module of the block.
package res_pkg;

   localparam int TABLE_SLOTS = 16;
   localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int PROBE_W     = $clog2(TABLE_SLOTS + 1);
   localparam int KEY_SHIFT   = 4;

   localparam logic [1:0] CMD_CHECK     = 2'd0;
   localparam logic [1:0] CMD_FLUSH     = 2'd1;
   localparam logic [1:0] CMD_FLUSH_ALL = 2'd2;
   localparam logic [1:0] CMD_UNUSED    = 2'd3;

   localparam logic [1:0] CSR_ENABLE    = 2'd0;
   localparam logic [1:0] CSR_WINDOW    = 2'd1;
   localparam logic [1:0] CSR_MAX_COUNT = 2'd2;

   localparam logic KIND_FINAL   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [31:0]       key;
      logic [31:0]       hash;
      logic [31:0]       now;
      logic [SLOT_W-1:0] start;
   } cmd_item_type;

   typedef struct packed {
      logic        enabled;
      logic [15:0] window;
      logic [15:0] max_count;
   } cfg_type;

   typedef struct packed {
      logic        item_kind;
      logic        suppress;
      logic [15:0] repeat_total;
      logic        last_of_run;
   } rsp_item_type;

endpackage

@@ rtl/res_if.sv @@
// Valid/ready channel interfaces for commands and results.
// Standalone; no package needed.
interface res_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] source_id;
   logic [31:0] message_hash;
   logic [31:0] time_seconds;

   modport source(output valid, cmd, source_id, message_hash, time_seconds, input ready);
   modport sink(input valid, cmd, source_id, message_hash, time_seconds, output ready);
endinterface

interface res_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic        suppress;
   logic [15:0] repeat_total;
   logic        last_of_run;

   modport source(output valid, item_kind, suppress, repeat_total, last_of_run, input ready);
   modport sink(input valid, item_kind, suppress, repeat_total, last_of_run, output ready);
endinterface

@@ rtl/repeat_event_suppressor.sv @@
// Top level of the repeat event suppressor: control registers, front end,
// command queue and back end. Depends on res_pkg, res_if, res_front,
// res_queue and res_back.
//
//   channel | direction | handshake     | moves
//   req     | in        | valid/ready   | cmd, source_id, message_hash, time_seconds
//   rsp     | out       | valid/ready   | item_kind, suppress, repeat_total, last_of_run
//   csr     | in        | csr_we only   | csr_index selects register, csr_wdata
//
// The front end registers a command in F_IDLE (start slot is a key bit
// field) and queues it from F_PUSH, waiting there while the queue is full.
// The back end pops it in B_IDLE, walks the slot table one slot a cycle in
// B_PROBE (1 to 16 probes), updates a found slot in B_ACT, ends in B_FINAL;
// a bypassed check skips to B_FINAL; a flush-all walks all 16 slots in B_SWEEP.
// Synchronous reset clears all slots at once; no clearing pass is needed.
// A stalled rsp holds the back end; the front end keeps filling the queue.
module repeat_event_suppressor (
   input  logic        clock,
   input  logic        reset,
   res_req_if.sink     req,
   res_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import res_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         q_push, q_full, q_pop, q_empty;
   cmd_item_type q_push_item, q_pop_item;

   // control registers; write only while the block is idle (the block does not enforce it)
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:    cfg_in.enabled   = csr_wdata[0];
            CSR_WINDOW:    cfg_in.window    = csr_wdata;
            CSR_MAX_COUNT: cfg_in.max_count = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{1'b0, 16'd30, 16'd100};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   res_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full)
   );

   res_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .empty     (q_empty)
   );

   res_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .pop      (q_pop),
      .pop_item (q_pop_item),
      .empty    (q_empty),
      .rsp      (rsp)
   );

endmodule

@@ rtl/res_queue.sv @@
// Two-entry command queue between front end and back end.
// Depends on res_pkg.
module res_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  res_pkg::cmd_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output res_pkg::cmd_item_type pop_item,
   output logic                  empty
);
   import res_pkg::*;

   cmd_item_type mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ (push & ~full);
      rd_ptr_in = rd_ptr_ff ^ (pop & ~empty);
      count_in  = count_ff + 2'(push & ~full) - 2'(pop & ~empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/res_front.sv @@
// Front end: takes commands, works out the probe start slot, queues them.
// Depends on res_pkg and res_if.
module res_front (
   input  logic                  clock,
   input  logic                  reset,
   res_req_if.sink               req,
   output logic                  push,
   output res_pkg::cmd_item_type push_item,
   input  logic                  full
);
   import res_pkg::*;

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_PUSH = 2'b10
   } fstate_type;

   fstate_type   state_ff, state_in;
   cmd_item_type item_ff, item_in;

   assign req.ready = (state_ff == F_IDLE);
   assign push      = (state_ff == F_PUSH);
   assign push_item = item_ff;

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req.valid) begin
               item_in.cmd  = req.cmd;
               item_in.key  = req.source_id;
               item_in.hash = req.message_hash;
               item_in.now  = req.time_seconds;
               // slot count is a power of two: the start slot is a bit field of the key
               item_in.start = SLOT_W'((req.source_id >> KEY_SHIFT) % TABLE_SLOTS);
               state_in      = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

@@ rtl/res_back.sv @@
// Back end: slot table, probe/flush sequencer and result output register.
// Depends on res_pkg and res_if.
module res_back (
   input  logic                  clock,
   input  logic                  reset,
   input  res_pkg::cfg_type      cfg,
   output logic                  pop,
   input  res_pkg::cmd_item_type pop_item,
   input  logic                  empty,
   res_rsp_if.source             rsp
);
   import res_pkg::*;

   typedef enum logic [4:0] {
      B_IDLE  = 5'b00001,
      B_PROBE = 5'b00010,
      B_ACT   = 5'b00100,
      B_SWEEP = 5'b01000,
      B_FINAL = 5'b10000
   } bstate_type;

   logic [31:0] slot_src_ff  [TABLE_SLOTS];
   logic [31:0] slot_hash_ff [TABLE_SLOTS];
   logic [15:0] slot_rep_ff  [TABLE_SLOTS];
   logic [31:0] slot_time_ff [TABLE_SLOTS];

   bstate_type         state_ff, state_in;
   cmd_item_type       cur_ff, cur_in;
   logic [SLOT_W-1:0]  ptr_ff, ptr_in;
   logic [PROBE_W-1:0] probes_ff, probes_in;
   logic               sup_ff, sup_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   logic        wr_en;
   logic [31:0] wr_src, wr_hash, wr_time;
   logic [15:0] wr_rep;
   logic [31:0] rd_src, rd_hash, rd_time, age;
   logic [15:0] rd_rep;
   logic        out_free, emit, last_slot, need;

   assign rd_src  = slot_src_ff[ptr_ff];
   assign rd_hash = slot_hash_ff[ptr_ff];
   assign rd_rep  = slot_rep_ff[ptr_ff];
   assign rd_time = slot_time_ff[ptr_ff];
   assign age     = cur_ff.now - rd_time;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign last_slot = (ptr_ff == SLOT_W'(TABLE_SLOTS - 1));
   assign need      = (rd_src != 32'd0) && (rd_rep > 16'd1);

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.item_kind    = rsp_item_ff.item_kind;
   assign rsp.suppress     = rsp_item_ff.suppress;
   assign rsp.repeat_total = rsp_item_ff.repeat_total;
   assign rsp.last_of_run  = rsp_item_ff.last_of_run;

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      ptr_in      = ptr_ff;
      probes_in   = probes_ff;
      sup_in      = sup_ff;
      pop         = 1'b0;
      emit        = 1'b0;
      rsp_item_in = rsp_item_ff;
      wr_en       = 1'b0;
      wr_src      = rd_src;
      wr_hash     = rd_hash;
      wr_rep      = rd_rep;
      wr_time     = rd_time;
      unique case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop       = 1'b1;
               cur_in    = pop_item;
               sup_in    = 1'b0;
               ptr_in    = pop_item.start;
               probes_in = '0;
               case (pop_item.cmd)
                  CMD_CHECK: state_in = (cfg.enabled && pop_item.key != 32'd0) ?
                                        B_PROBE : B_FINAL;
                  CMD_FLUSH: state_in = (pop_item.key != 32'd0) ? B_PROBE : B_FINAL;
                  CMD_FLUSH_ALL: begin
                     ptr_in   = '0;
                     state_in = B_SWEEP;
                  end
                  default: state_in = B_FINAL;
               endcase
            end
         end
         B_PROBE: begin
            if (rd_src == cur_ff.key) begin
               state_in = B_ACT;
            end else if (rd_src == 32'd0) begin
               if (cur_ff.cmd == CMD_CHECK) begin
                  // claim the empty slot; ACT then starts a new run in it
                  wr_en    = 1'b1;
                  wr_src   = cur_ff.key;
                  wr_hash  = '0;
                  wr_rep   = '0;
                  wr_time  = '0;
                  state_in = B_ACT;
               end else begin
                  state_in = B_FINAL;
               end
            end else if (probes_ff == PROBE_W'(TABLE_SLOTS - 1)) begin
               state_in = B_FINAL;
            end else begin
               ptr_in    = last_slot ? '0 : ptr_ff + 1'b1;
               probes_in = probes_ff + 1'b1;
            end
         end
         B_ACT: begin
            if (out_free) begin
               wr_en    = 1'b1;
               state_in = B_FINAL;
               rsp_item_in = '{KIND_SUMMARY, 1'b0, rd_rep, 1'b0};
               if (cur_ff.cmd == CMD_CHECK) begin
                  if (rd_rep != 16'd0 && rd_hash == cur_ff.hash) begin
                     if (age >= {16'd0, cfg.window} || rd_rep >= cfg.max_count) begin
                        emit    = 1'b1;
                        wr_rep  = '0;
                        wr_time = cur_ff.now;
                     end else begin
                        wr_rep = rd_rep + 16'd1;
                        sup_in = 1'b1;
                     end
                  end else begin
                     emit    = (rd_rep != 16'd0);
                     wr_hash = cur_ff.hash;
                     wr_rep  = 16'd1;
                     wr_time = cur_ff.now;
                  end
               end else begin
                  emit = (rd_rep > 16'd1);
                  rsp_item_in.repeat_total = rd_rep - 16'd1;
                  wr_rep = '0;
               end
            end
         end
         B_SWEEP: begin
            if (!need || out_free) begin
               if (need) begin
                  emit        = 1'b1;
                  rsp_item_in = '{KIND_SUMMARY, 1'b0, rd_rep - 16'd1, 1'b0};
                  wr_en       = 1'b1;
                  wr_rep      = '0;
               end
               if (last_slot) begin
                  state_in = B_FINAL;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end
         B_FINAL: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_item_in = '{KIND_FINAL, sup_ff, 16'd0, 1'b1};
               state_in    = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_src_ff[i]  <= '0;
            slot_hash_ff[i] <= '0;
            slot_rep_ff[i]  <= '0;
            slot_time_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            slot_src_ff[ptr_ff]  <= wr_src;
            slot_hash_ff[ptr_ff] <= wr_hash;
            slot_rep_ff[ptr_ff]  <= wr_rep;
            slot_time_ff[ptr_ff] <= wr_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      ptr_ff      <= ptr_in;
      probes_ff   <= probes_in;
      sup_ff      <= sup_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

@@ tb/sv/repeat_event_suppressor_test.sv @@
// Self-checking testbench for repeat_event_suppressor: directed and random
// commands against a behavioral slot-table predictor. Depends on res_pkg,
// res_if and the block's RTL.
`timescale 1ns / 1ps

module repeat_event_suppressor_test;
   import res_pkg::*;

   localparam int MAX_CYCLES = 1000000;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] source_id;
      logic [31:0] message_hash;
      logic [31:0] time_seconds;
   } command_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_we    = 1'b0;
   logic [1:0]  csr_index = CSR_ENABLE;
   logic [15:0] csr_wdata = '0;

   res_req_if req ();
   res_rsp_if rsp ();

   repeat_event_suppressor dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Predictor copy of the table and the control registers.
   logic        dedup_on;
   logic [15:0] window_limit;
   logic [15:0] count_limit;
   logic [31:0] tbl_source  [TABLE_SLOTS];
   logic [31:0] tbl_hash    [TABLE_SLOTS];
   logic [15:0] tbl_repeats [TABLE_SLOTS];
   logic [31:0] tbl_first   [TABLE_SLOTS];

   command_type  pending_cmds[$];
   rsp_item_type expected_rsp[$];

   int  mismatches   = 0;
   int  cycle_count  = 0;
   int  transfers_in = 0;
   int  transfers_out = 0;
   int  summaries_seen = 0;
   bit  hold_rsp     = 1'b0;   // asks the receiver for a long hold-off
   int  hold_left    = 0;      // hold-off cycles left, counted by the receiver
   int  burst_left   = 0;
   int  gap_left     = 0;
   int  stall_phase  = 0;

   function automatic rsp_item_type make_rsp(logic kind, logic sup, logic [15:0] total,
                                             logic last);
      rsp_item_type r;
      r.item_kind = kind;
      r.suppress = sup;
      r.repeat_total = total;
      r.last_of_run = last;
      return r;
   endfunction

   // Linear probe from (key >> 4) mod slots; optionally claims the first empty slot.
   function automatic int find_slot(logic [31:0] key, bit claim);
      int start;
      int p;
      start = (key >> KEY_SHIFT) % TABLE_SLOTS;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         p = (start + i) % TABLE_SLOTS;
         if (tbl_source[p] == key) return p;
         if (tbl_source[p] == 0) begin
            if (!claim) return -1;
            tbl_source[p] = key;
            tbl_hash[p] = '0;
            tbl_repeats[p] = '0;
            tbl_first[p] = '0;
            return p;
         end
      end
      return -1;
   endfunction

   // Applies one accepted command to the predictor and queues its results.
   task automatic predict_command(command_type c);
      int s;
      logic sup;
      logic [15:0] cnt;
      logic [31:0] age;
      sup = 1'b0;
      if (c.cmd == CMD_CHECK) begin
         if (dedup_on && c.source_id != 0) begin
            s = find_slot(c.source_id, 1'b1);
            if (s >= 0) begin
               cnt = tbl_repeats[s];
               if (cnt != 0 && tbl_hash[s] == c.message_hash) begin
                  age = c.time_seconds - tbl_first[s];
                  if (age >= {16'd0, window_limit} || cnt >= count_limit) begin
                     // run ended by window or count limit
                     expected_rsp.push_back(make_rsp(KIND_SUMMARY, 1'b0, cnt, 1'b0));
                     tbl_repeats[s] = '0;
                     tbl_first[s] = c.time_seconds;
                  end else begin
                     tbl_repeats[s] = cnt + 16'd1;
                     sup = 1'b1;
                  end
               end else begin
                  if (cnt != 0)
                     expected_rsp.push_back(make_rsp(KIND_SUMMARY, 1'b0, cnt, 1'b0));
                  tbl_hash[s] = c.message_hash;
                  tbl_repeats[s] = 16'd1;
                  tbl_first[s] = c.time_seconds;
               end
            end
         end
      end else if (c.cmd == CMD_FLUSH) begin
         if (c.source_id != 0) begin
            s = find_slot(c.source_id, 1'b0);
            if (s >= 0) begin
               if (tbl_repeats[s] > 1)
                  expected_rsp.push_back(make_rsp(KIND_SUMMARY, 1'b0,
                                                  tbl_repeats[s] - 16'd1, 1'b0));
               tbl_repeats[s] = '0;
            end
         end
      end else if (c.cmd == CMD_FLUSH_ALL) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (tbl_source[i] != 0 && tbl_repeats[i] > 1) begin
               expected_rsp.push_back(make_rsp(KIND_SUMMARY, 1'b0,
                                               tbl_repeats[i] - 16'd1, 1'b0));
               tbl_repeats[i] = '0;
            end
         end
      end
      expected_rsp.push_back(make_rsp(KIND_FINAL, sup, 16'd0, 1'b1));
   endtask

   // Driver: bursts of offers separated by random gaps; valid held across
   // back-to-back transfers without being dropped in between.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            predict_command({req.cmd, req.source_id, req.message_hash, req.time_seconds});
            transfers_in++;
         end
         if (req.valid && !req.ready) begin
            // keep offering the same item
         end else if (gap_left > 0) begin
            gap_left--;
            req.valid <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            command_type c;
            c = pending_cmds.pop_front();
            req.valid <= 1'b1;
            {req.cmd, req.source_id, req.message_hash, req.time_seconds} <= c;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
            end
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   initial begin
      req.cmd = CMD_CHECK;
      req.source_id = '0;
      req.message_hash = '0;
      req.time_seconds = '0;
      req.valid = 1'b0;
      rsp.ready = 1'b0;
   end

   // Receiver: its own stall pattern, plus a long hold-off counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         stall_phase <= (stall_phase + 1) % 64;
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
         end else if (hold_rsp) begin
            hold_left <= 600;
            rsp.ready <= 1'b0;
         end else if (stall_phase < 20)
            rsp.ready <= 1'b1;  // stretch with no stalls
         else
            rsp.ready <= ($urandom_range(0, 2) != 0);
      end
   end

   // Monitor: checks each result transfer against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         rsp_item_type got;
         rsp_item_type want;
         got = make_rsp(rsp.item_kind, rsp.suppress, rsp.repeat_total, rsp.last_of_run);
         transfers_out++;
         if (got.item_kind == KIND_SUMMARY) summaries_seen++;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result kind=%0d sup=%0d total=%0d last=%0d",
                        got.item_kind, got.suppress, got.repeat_total, got.last_of_run);
         end else begin
            want = expected_rsp.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"ERROR: result %0d expected kind=%0d sup=%0d total=%0d ",
                            "last=%0d, got kind=%0d sup=%0d total=%0d last=%0d"},
                           transfers_out, want.item_kind, want.suppress,
                           want.repeat_total, want.last_of_run, got.item_kind,
                           got.suppress, got.repeat_total, got.last_of_run);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_rsp.size());
         $display("repeat_event_suppressor test failed");
         $finish;
      end
   end

   function automatic command_type mk_cmd(logic [1:0] op, logic [31:0] key,
                                          logic [31:0] hash, logic [31:0] now);
      command_type c;
      c.cmd = op;
      c.source_id = key;
      c.message_hash = hash;
      c.time_seconds = now;
      return c;
   endfunction

   // Register write; also updates the predictor copy.
   task automatic write_csr(logic [1:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ENABLE:    dedup_on = value[0];
         CSR_WINDOW:    window_limit = value;
         CSR_MAX_COUNT: count_limit = value;
         default: begin
         end
      endcase
   endtask

   // Waits until the queue has drained and every expected result has come.
   task automatic wait_idle();
      while (pending_cmds.size() != 0 || req.valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Random content biased toward repeat runs on a small set of sources.
   logic [31:0] src_pool [8];
   logic [31:0] hash_pool [3];
   logic [31:0] clock_secs;

   function automatic command_type random_cmd();
      int r;
      logic [1:0] op;
      logic [31:0] key;
      logic [31:0] hash;
      r = $urandom_range(0, 99);
      op = (r < 82) ? CMD_CHECK : (r < 92) ? CMD_FLUSH : (r < 97) ? CMD_FLUSH_ALL :
           CMD_UNUSED;
      key = ($urandom_range(0, 15) == 0) ? $urandom : src_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 40) == 0) key = '0;
      hash = ($urandom_range(0, 7) == 0) ? $urandom : hash_pool[$urandom_range(0, 2)];
      clock_secs += 32'($urandom_range(0, 3));
      if ($urandom_range(0, 60) == 0) clock_secs = $urandom;
      return mk_cmd(op, key, hash, clock_secs);
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < 8; i++) src_pool[i] = $urandom;
      // same start slot as the first source
      src_pool[1] = {src_pool[0][31:4], 4'($urandom_range(0, 15))};
      for (int i = 0; i < 3; i++) hash_pool[i] = $urandom;
      for (int i = 0; i < count; i++) pending_cmds.push_back(random_cmd());
   endtask

   initial begin
      logic [31:0] k;
      dedup_on = 1'b0;
      window_limit = 16'd30;
      count_limit = 16'd100;
      clock_secs = $urandom;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         tbl_source[i] = '0;
         tbl_hash[i] = '0;
         tbl_repeats[i] = '0;
         tbl_first[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Disabled checks pass through; unused command code acknowledged only.
      pending_cmds.push_back(mk_cmd(CMD_CHECK, 32'h0000_0123, 32'hAAAA_5555, 32'd0));
      pending_cmds.push_back(mk_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF));
      wait_idle();

      write_csr(CSR_ENABLE, 16'd1);
      write_csr(CSR_WINDOW, 16'd10);
      write_csr(CSR_MAX_COUNT, 16'd3);
      k = 32'h0000_0050;
      // new message, repeats, count limit, hash change, source zero, flushes
      pending_cmds.push_back(mk_cmd(CMD_CHECK, 32'd0, 32'd1, 32'd0));
      pending_cmds.push_back(mk_cmd(CMD_CHECK, k, 32'h1111, 32'd100));
      pending_cmds.push_back(mk_cmd(CMD_CHECK, k, 32'h1111, 32'd101));
      pending_cmds.push_back(mk_cmd(CMD_CHECK, k, 32'h1111, 32'd102));
      pending_cmds.push_back(mk_cmd(CMD_CHECK, k, 32'h1111, 32'd103));
      pending_cmds.push_back(mk_cmd(CMD_CHECK, k, 32'h2222, 32'd104));
      pending_cmds.push_back(mk_cmd(CMD_CHECK, k, 32'h2222, 32'd200));
      pending_cmds.push_back(mk_cmd(CMD_CHECK, k, 32'h2222, 32'd201));
      pending_cmds.push_back(mk_cmd(CMD_FLUSH, k, 32'd0, 32'd0));
      pending_cmds.push_back(mk_cmd(CMD_FLUSH, 32'h0000_0777, 32'd0, 32'd0));
      pending_cmds.push_back(mk_cmd(CMD_FLUSH, 32'd0, 32'd0, 32'd0));
      // time wrap: age taken mod 2^32
      pending_cmds.push_back(mk_cmd(CMD_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE));
      pending_cmds.push_back(mk_cmd(CMD_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0003));
      // fill every slot through one start slot, then overflow the table
      for (int i = 0; i < TABLE_SLOTS + 2; i++)
         pending_cmds.push_back(mk_cmd(CMD_CHECK, 32'h1000_0000 + i, 32'h3, 32'd5));
      wait_idle();
      // duplicates on three sources, then flush-all emits a summary per slot with repeats
      for (int i = 0; i < 3; i++)
         pending_cmds.push_back(mk_cmd(CMD_CHECK, 32'h1000_0000 + i, 32'h3, 32'd6));
      pending_cmds.push_back(mk_cmd(CMD_FLUSH_ALL, 32'd0, 32'd0, 32'd0));
      wait_idle();

      // Random phases across several register settings; table persists.
      write_csr(CSR_WINDOW, 16'd65535);
      write_csr(CSR_MAX_COUNT, 16'd65535);
      random_phase(100);
      // long receiver hold-off while commands keep arriving
      wait (transfers_in > 50);
      hold_rsp = 1'b1;
      wait (hold_left != 0);
      hold_rsp = 1'b0;
      wait_idle();

      write_csr(CSR_WINDOW, 16'd0);
      write_csr(CSR_MAX_COUNT, 16'd0);
      random_phase(60);
      wait_idle();

      write_csr(CSR_WINDOW, 16'd4);
      write_csr(CSR_MAX_COUNT, 16'd5);
      random_phase(120);
      wait_idle();

      write_csr(CSR_ENABLE, 16'd0);
      random_phase(30);
      wait_idle();

      write_csr(CSR_ENABLE, 16'd1);
      write_csr(CSR_WINDOW, 16'd30);
      write_csr(CSR_MAX_COUNT, 16'd1);
      random_phase(90);
      pending_cmds.push_back(mk_cmd(CMD_FLUSH_ALL, $urandom, $urandom, $urandom));
      wait_idle();

      $display("covered %0d commands and %0d results (%0d repeat summaries)",
               transfers_in, transfers_out, summaries_seen);
      $display("over enable, window and count-limit settings including extremes");
      if (mismatches == 0) begin
         $display("repeat_event_suppressor test passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("repeat_event_suppressor test failed");
      end
      $finish;
   end

endmodule

@@ repeat_event_suppressor.f @@
rtl/res_pkg.sv
rtl/res_if.sv
rtl/res_queue.sv
rtl/res_front.sv
rtl/res_back.sv
rtl/repeat_event_suppressor.sv
tb/sv/repeat_event_suppressor_test.sv
